/* rtl/bts_pkg.sv */
// shared types and constants for the buzzer tone sequencer
package bts_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [4:0] PITCH_STEP_HZ = 5'd15;
  localparam logic [8:0] THIRD_MUL     = 9'd341;
  localparam int         THIRD_SHIFT   = 10;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  typedef enum logic [2:0] {
    CFG_PITCH_OFFSET = 3'd0,
    CFG_LENGTH_SCALE = 3'd1,
    CFG_BEEP_LEVEL   = 3'd2,
    CFG_VARIO_LEVEL  = 3'd3,
    CFG_LOWEST_FREQ  = 3'd4,
    CFG_HIGHEST_FREQ = 3'd5,
    CFG_TICK_MS      = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] freq;
    logic [15:0] len;
    logic [15:0] pause;
    logic [3:0]  reps;
    logic        now;
    logic        bg;
    logic [7:0]  step;
  } tone_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

endpackage

/* rtl/bts_queue.sv */
// small fifo of pending tone requests
module bts_queue
  import bts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  q_ctrl_t           ctrl,
  input  tone_t             wr_tone,
  output tone_t             head,
  output logic [QCNT_W-1:0] count
);

  tone_t             entries [QDEPTH];
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] wr_ptr;

  // entries carry no reset, only slots that were pushed are ever read
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entries[wr_ptr] <= wr_tone;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (ctrl.push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (ctrl.pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (ctrl.push && !ctrl.pop) begin
        count <= count + 1'b1;
      end else if (ctrl.pop && !ctrl.push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head = entries[rd_ptr];

endmodule

/* rtl/buzzer_tone_sequencer.sv */
// buzzer tone sequencer: tone requests and timer ticks in, buzzer state out
//
// in channel (in_valid/in_ready) carries either a tone request or a timer
// tick, selected by kind. every transaction yields exactly one result on the
// out channel (out_valid/out_ready): buzzer enable, frequency, level, busy
// flag and number of queued tones after that transaction was applied.
// a transaction lands in an input register; the sequencer state and the
// result register are updated together when it moves on from there, which
// is once the result register is empty or its result is being taken. one
// transaction per cycle is sustained while the receiver takes every result;
// the single state update per cycle sets that figure.
// when the receiver stalls, the result register holds and the input register
// takes at most one more transaction; after that in_ready drops until the
// result is taken.
// the configuration port writes one register per cycle with cfg_we high; the
// user must use it only while the block is idle, the block does not enforce
// that. reset clears all sequencer state and the queue pointers and loads the
// register defaults (lowest 150 Hz, highest 15000 Hz, 10 ms per tick).
module buzzer_tone_sequencer
  import bts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [15:0]        tone_freq,
  input  logic [15:0]        tone_len,
  input  logic [15:0]        tone_pause,
  input  logic [3:0]         repeat_count,
  input  logic               urgent,
  input  logic               background,
  input  logic signed [7:0]  sweep_step,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               sounding,
  output logic [15:0]        out_freq,
  output logic signed [2:0]  out_level,
  output logic               busy_res,
  output logic [2:0]         queued
);

  function automatic logic [15:0] scale_len(input logic [15:0] len,
                                            input logic signed [2:0] s);
    logic [25:0] third;
    logic [17:0] mult;
    logic [15:0] r;
    third = 26'(len) * 26'(THIRD_MUL);
    mult  = 18'(len) * 18'(3'(s[1:0]) + 3'd1);
    if (s == -3'sd1) begin
      r = len >> 1;
    end else if (s < 0) begin
      r = third[THIRD_SHIFT +: 16];
    end else if (s > 0) begin
      r = mult[15:0];
    end else begin
      r = len;
    end
    return r;
  endfunction

  // configuration registers
  logic [4:0]        pitch_offset;
  logic signed [2:0] length_scale;
  logic [2:0]        beep_level;
  logic [2:0]        vario_level;
  logic [15:0]       lowest_freq;
  logic [15:0]       highest_freq;
  logic [7:0]        tick_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_offset <= '0;
      length_scale <= '0;
      beep_level   <= '0;
      vario_level  <= '0;
      lowest_freq  <= 16'd150;
      highest_freq <= 16'd15000;
      tick_ms      <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PITCH_OFFSET: pitch_offset <= cfg_data[4:0];
        CFG_LENGTH_SCALE: length_scale <= cfg_data[2:0];
        CFG_BEEP_LEVEL:   beep_level   <= cfg_data[2:0];
        CFG_VARIO_LEVEL:  vario_level  <= cfg_data[2:0];
        CFG_LOWEST_FREQ:  lowest_freq  <= cfg_data;
        CFG_HIGHEST_FREQ: highest_freq <= cfg_data;
        CFG_TICK_MS:      tick_ms      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input register
  logic  in_reg_v;
  logic  in_kind;
  tone_t in_tone;
  logic  advance;

  assign advance  = in_reg_v && (!out_valid || out_ready);
  assign in_ready = !in_reg_v || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_v <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_reg_v <= 1'b1;
    end else if (advance) begin
      in_reg_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_kind       <= kind;
      in_tone.freq  <= tone_freq;
      in_tone.len   <= tone_len;
      in_tone.pause <= tone_pause;
      in_tone.reps  <= repeat_count;
      in_tone.now   <= urgent;
      in_tone.bg    <= background;
      in_tone.step  <= sweep_step;
    end
  end

  // sequencer state
  logic [15:0] time_left, time_left_next;
  logic [15:0] pause_left, pause_left_next;
  logic [3:0]  repeats_left, repeats_left_next;
  logic [15:0] cur_freq, cur_freq_next;
  logic [15:0] saved_freq, saved_freq_next;
  logic [15:0] saved_len, saved_len_next;
  logic [15:0] saved_pause, saved_pause_next;
  logic        saved_background, saved_background_next;
  logic [7:0]  saved_step, saved_step_next;
  logic        enabled, enabled_next;
  logic [2:0]  applied_level, applied_level_next;

  q_ctrl_t           q_ctrl;
  tone_t             q_head;
  logic [QCNT_W-1:0] q_count;

  bts_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (q_ctrl),
    .wr_tone (in_tone),
    .head    (q_head),
    .count   (q_count)
  );

  // start path shared by new requests and tones popped from the queue
  tone_t             src;
  logic [15:0]       src_tl;
  logic [QCNT_W-1:0] src_qc;
  logic              do_start_path;
  logic              drop_bg;
  logic              enq_case;
  logic [15:0]       start_freq;
  logic [15:0]       start_len;
  logic              q_full;

  // sweep path
  logic signed [16:0] sweep_prod;
  logic signed [18:0] sweep_sum;
  logic signed [18:0] low_s;
  logic signed [18:0] high_s;
  logic signed [18:0] sweep_clamp;

  assign q_full = (q_count == QCNT_W'(QDEPTH));

  always_comb begin
    if (in_kind == KIND_REQUEST) begin
      src    = in_tone;
      src_tl = time_left;
      src_qc = q_count;
    end else begin
      // popping only happens with time_left at zero, count seen after the pop
      src    = q_head;
      src_tl = '0;
      src_qc = q_count - 1'b1;
    end
    drop_bg  = src.bg && !src.now &&
               (src_tl != '0 || repeats_left != '0 || src_qc != '0);
    enq_case = !src.now && !saved_background && (src_tl != '0);
    if (src.bg) begin
      start_freq = src.freq;
      start_len  = src.len;
    end else begin
      start_freq = src.freq + 16'(pitch_offset) * 16'(PITCH_STEP_HZ);
      start_len  = scale_len(src.len, length_scale);
    end
  end

  always_comb begin
    sweep_prod  = $signed({1'b0, tick_ms}) * $signed(saved_step);
    sweep_sum   = $signed({3'b000, cur_freq}) + {{2{sweep_prod[16]}}, sweep_prod};
    low_s       = $signed({3'b000, lowest_freq});
    high_s      = $signed({3'b000, highest_freq});
    sweep_clamp = (sweep_sum < low_s) ? low_s : sweep_sum;
    if (sweep_clamp > high_s) begin
      sweep_clamp = high_s;
    end
  end

  always_comb begin
    time_left_next        = time_left;
    pause_left_next       = pause_left;
    repeats_left_next     = repeats_left;
    cur_freq_next         = cur_freq;
    saved_freq_next       = saved_freq;
    saved_len_next        = saved_len;
    saved_pause_next      = saved_pause;
    saved_background_next = saved_background;
    saved_step_next       = saved_step;
    enabled_next          = enabled;
    applied_level_next    = applied_level;
    q_ctrl                = '0;
    do_start_path         = 1'b0;

    if (advance) begin
      if (in_kind == KIND_REQUEST) begin
        do_start_path = 1'b1;
      end else if (time_left != '0) begin
        if (time_left > {8'h00, tick_ms}) begin
          time_left_next = time_left - {8'h00, tick_ms};
          if (saved_step != '0) begin
            cur_freq_next      = sweep_clamp[15:0];
            enabled_next       = 1'b1;
            applied_level_next = beep_level;
          end
        end else begin
          time_left_next = '0;
          enabled_next   = 1'b0;
          if (pause_left != '0) begin
            time_left_next  = pause_left;
            pause_left_next = '0;
          end else if (repeats_left != '0) begin
            repeats_left_next  = repeats_left - 1'b1;
            cur_freq_next      = saved_freq;
            time_left_next     = saved_len;
            pause_left_next    = saved_pause;
            enabled_next       = 1'b1;
            applied_level_next = beep_level;
          end
        end
      end else if (q_count != '0) begin
        q_ctrl.pop    = 1'b1;
        do_start_path = 1'b1;
      end

      if (do_start_path && !drop_bg) begin
        if (enq_case) begin
          // only a new request can land here; background ones were dropped
          q_ctrl.push = !src.bg && !q_full;
        end else begin
          cur_freq_next         = start_freq;
          time_left_next        = start_len;
          pause_left_next       = src.pause;
          repeats_left_next     = src.reps;
          saved_freq_next       = start_freq;
          saved_len_next        = start_len;
          saved_pause_next      = src.pause;
          saved_background_next = src.bg;
          saved_step_next       = src.step;
          enabled_next          = 1'b1;
          applied_level_next    = src.bg ? vario_level : beep_level;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_left        <= '0;
      pause_left       <= '0;
      repeats_left     <= '0;
      cur_freq         <= '0;
      saved_freq       <= '0;
      saved_len        <= '0;
      saved_pause      <= '0;
      saved_background <= 1'b0;
      saved_step       <= '0;
      enabled          <= 1'b0;
      applied_level    <= '0;
    end else begin
      time_left        <= time_left_next;
      pause_left       <= pause_left_next;
      repeats_left     <= repeats_left_next;
      cur_freq         <= cur_freq_next;
      saved_freq       <= saved_freq_next;
      saved_len        <= saved_len_next;
      saved_pause      <= saved_pause_next;
      saved_background <= saved_background_next;
      saved_step       <= saved_step_next;
      enabled          <= enabled_next;
      applied_level    <= applied_level_next;
    end
  end

  // result register, count reflects the push or pop of this transaction
  logic [QCNT_W-1:0] q_count_next;

  always_comb begin
    q_count_next = q_count;
    if (q_ctrl.push) begin
      q_count_next = q_count + 1'b1;
    end else if (q_ctrl.pop) begin
      q_count_next = q_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sounding  <= enabled_next;
      out_freq  <= cur_freq_next;
      out_level <= applied_level_next;
      busy_res  <= (time_left_next != '0);
      queued    <= 3'(q_count_next);
    end
  end

endmodule

/* rtl/bts_checker.sv */
// port-level checks for the buzzer tone sequencer, bound to the top level
module bts_checker
  import bts_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              sounding,
  input logic [15:0]       out_freq,
  input logic signed [2:0] out_level,
  input logic              busy_res,
  input logic [2:0]        queued
);

  // no result is left over from before reset
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // with the result register empty the input side never blocks
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  // queue occupancy never exceeds its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(queued) <= QDEPTH))
    else $error("queued count beyond queue depth");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sounding) && $stable(out_freq)
      && $stable(out_level) && $stable(busy_res) && $stable(queued))
    else $error("stalled result changed");

endmodule

bind buzzer_tone_sequencer bts_checker u_bts_checker (.*);

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// self-checking testbench for the buzzer tone sequencer with its own tone predictor
module tb_top;
  import bts_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic        sounding;
    logic [15:0] freq;
    logic [2:0]  level;
    logic        busy;
    logic [2:0]  queued;
  } buzz_out_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               kind;
  logic [15:0]        tone_freq;
  logic [15:0]        tone_len;
  logic [15:0]        tone_pause;
  logic [3:0]         repeat_count;
  logic               urgent;
  logic               background;
  logic signed [7:0]  sweep_step;
  logic               out_valid;
  logic               out_ready;
  logic               sounding;
  logic [15:0]        out_freq;
  logic signed [2:0]  out_level;
  logic               busy_res;
  logic [2:0]         queued;

  // predictor copy of the registers
  logic [4:0]        set_pitch;
  logic signed [2:0] set_scale, set_beep, set_vario;
  logic [15:0]       set_lo, set_hi;
  logic [7:0]        set_tick;

  // predictor copy of the sequencer state
  logic [15:0]       tone_left, pause_left, cur_hz, rep_hz, rep_len, rep_pause;
  logic [3:0]        reps_left;
  logic              rep_bg;
  logic signed [7:0] rep_step;
  logic              buzzer_on;
  logic [2:0]        level_now;
  tone_t             tone_fifo [QDEPTH];
  int                fifo_rd, fifo_wr, fifo_fill;

  buzz_out_t expected_buzz[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int phases = 0;
  int hold_cycles = 0;
  int cycle_count = 0;
  bit quiet_tx = 1'b0;
  bit quiet_rx = 1'b0;

  buzzer_tone_sequencer u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .tone_freq    (tone_freq),
    .tone_len     (tone_len),
    .tone_pause   (tone_pause),
    .repeat_count (repeat_count),
    .urgent       (urgent),
    .background   (background),
    .sweep_step   (sweep_step),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sounding     (sounding),
    .out_freq     (out_freq),
    .out_level    (out_level),
    .busy_res     (busy_res),
    .queued       (queued)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] scaled_length(input logic [15:0] len);
    int r;
    r = len;
    if (set_scale == -3'sd1) begin
      r = r / 2;
    end else if (set_scale < 0) begin
      r = (r * int'(THIRD_MUL)) >> THIRD_SHIFT;
    end else if (set_scale > 0) begin
      r = r * (1 + int'(set_scale));
    end
    return r[15:0];
  endfunction

  task automatic start_tone(input tone_t t);
    logic [15:0] f;
    logic [15:0] l;
    // background request gives way to anything in progress
    if (t.bg && !t.now && (tone_left != 0 || reps_left != 0 || fifo_fill != 0)) return;
    if (!t.now && !rep_bg && tone_left != 0) begin
      if (!t.bg && fifo_fill < QDEPTH) begin
        tone_fifo[fifo_wr] = t;
        fifo_wr = (fifo_wr + 1) % QDEPTH;
        fifo_fill++;
      end
      return;
    end
    f = t.freq;
    l = t.len;
    if (!t.bg) begin
      f = t.freq + set_pitch * PITCH_STEP_HZ;
      l = scaled_length(t.len);
    end
    cur_hz     = f;
    tone_left  = l;
    pause_left = t.pause;
    reps_left  = t.reps;
    rep_hz     = f;
    rep_len    = l;
    rep_pause  = t.pause;
    rep_bg     = t.bg;
    rep_step   = t.step;
    buzzer_on  = 1'b1;
    level_now  = t.bg ? set_vario : set_beep;
  endtask

  task automatic tick_tone();
    int    sum;
    tone_t t;
    if (tone_left != 0) begin
      if (tone_left > set_tick) begin
        tone_left = tone_left - set_tick;
        // sweep also runs during the pause and turns the buzzer back on
        if (rep_step != 0) begin
          sum = int'(cur_hz) + int'(set_tick) * int'(rep_step);
          if (sum < int'(set_lo)) sum = set_lo;
          if (sum > int'(set_hi)) sum = set_hi;
          cur_hz    = sum[15:0];
          buzzer_on = 1'b1;
          level_now = set_beep;
        end
      end else begin
        tone_left = '0;
        buzzer_on = 1'b0;
        if (pause_left != 0) begin
          tone_left  = pause_left;
          pause_left = '0;
        end else if (reps_left != 0) begin
          reps_left--;
          cur_hz     = rep_hz;
          tone_left  = rep_len;
          pause_left = rep_pause;
          buzzer_on  = 1'b1;
          level_now  = set_beep;
        end
      end
    end else if (fifo_fill != 0) begin
      t = tone_fifo[fifo_rd];
      fifo_rd = (fifo_rd + 1) % QDEPTH;
      fifo_fill--;
      start_tone(t);
    end
  endtask

  task automatic buzz_step(input logic k, input tone_t t);
    buzz_out_t r;
    if (k == KIND_TICK) tick_tone();
    else start_tone(t);
    r.sounding = buzzer_on;
    r.freq     = cur_hz;
    r.level    = level_now;
    r.busy     = (tone_left != 0);
    r.queued   = fifo_fill[2:0];
    expected_buzz.push_back(r);
  endtask

  function automatic tone_t make_tone(input logic [15:0] freq, input logic [15:0] len,
                                      input logic [15:0] pause, input logic [3:0] reps,
                                      input logic now, input logic bg, input logic [7:0] step);
    tone_t t;
    t.freq  = freq;
    t.len   = len;
    t.pause = pause;
    t.reps  = reps;
    t.now   = now;
    t.bg    = bg;
    t.step  = step;
    return t;
  endfunction

  function automatic tone_t random_tone();
    tone_t t;
    if ($urandom_range(9) == 0) t.freq = $urandom_range(1) ? 16'hffff : 16'h0000;
    else t.freq = 16'($urandom);
    // mostly short tones so that they expire and the queue moves
    t.len = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
    if ($urandom_range(2) == 0) t.pause = '0;
    else if ($urandom_range(9) == 0) t.pause = 16'($urandom);
    else t.pause = 16'($urandom_range(1, 40));
    t.reps = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
    t.now  = ($urandom_range(99) < 20);
    t.bg   = ($urandom_range(99) < 25);
    t.step = ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom);
    return t;
  endfunction

  task automatic send_item(input logic k, input tone_t t);
    @(negedge clk);
    if (!quiet_tx) begin
      while ($urandom_range(99) < 27) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid     <= 1'b1;
    kind         <= k;
    tone_freq    <= t.freq;
    tone_len     <= t.len;
    tone_pause   <= t.pause;
    repeat_count <= t.reps;
    urgent       <= t.now;
    background   <= t.bg;
    sweep_step   <= t.step;
    do @(posedge clk); while (!in_ready);
    buzz_step(k, t);
    sent++;
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, random_tone());
  endtask

  task automatic send_random();
    if ($urandom_range(99) < 55) send_item(KIND_TICK, random_tone());
    else send_item(KIND_REQUEST, random_tone());
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_buzz.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_PITCH_OFFSET: set_pitch = val[4:0];
      CFG_LENGTH_SCALE: set_scale = val[2:0];
      CFG_BEEP_LEVEL:   set_beep  = val[2:0];
      CFG_VARIO_LEVEL:  set_vario = val[2:0];
      CFG_LOWEST_FREQ:  set_lo    = val;
      CFG_HIGHEST_FREQ: set_hi    = val;
      CFG_TICK_MS:      set_tick  = val[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [4:0] pitch, input logic [2:0] scale,
                                input logic [2:0] beep, input logic [2:0] vario,
                                input logic [15:0] lo, input logic [15:0] hi,
                                input logic [7:0] tick_len);
    wait_drained();
    write_reg(CFG_PITCH_OFFSET, 16'(pitch));
    write_reg(CFG_LENGTH_SCALE, 16'(scale));
    write_reg(CFG_BEEP_LEVEL, 16'(beep));
    write_reg(CFG_VARIO_LEVEL, 16'(vario));
    write_reg(CFG_LOWEST_FREQ, lo);
    write_reg(CFG_HIGHEST_FREQ, hi);
    write_reg(CFG_TICK_MS, 16'(tick_len));
    @(negedge clk);
    cfg_we <= 1'b0;
    phases++;
  endtask

  task automatic random_settings();
    logic [4:0]  pitch;
    logic [15:0] lo, hi, swap;
    logic [7:0]  tk;
    int          roll;
    pitch = ($urandom_range(99) < 80) ? 5'($urandom_range(0, 20)) : 5'($urandom_range(21, 31));
    lo = 16'($urandom_range(0, 2000));
    hi = 16'($urandom_range(2000, 65535));
    // sometimes an inverted clamp window
    if ($urandom_range(99) < 15) begin
      swap = lo;
      lo   = hi;
      hi   = swap;
    end
    roll = $urandom_range(99);
    if (roll < 5) tk = 8'd0;
    else if (roll < 15) tk = 8'd255;
    else tk = 8'($urandom_range(1, 20));
    apply_settings(pitch, 3'($urandom), 3'($urandom), 3'($urandom), lo, hi, tk);
  endtask

  task automatic test_queue_and_drop();
    apply_settings(5'd20, 3'd0, 3'sd2, -3'sd2, 16'd150, 16'd15000, 8'd10);
    // idle start, frequency wraps with the pitch offset
    send_item(KIND_REQUEST, make_tone(16'hffff, 16'd25, 16'd10, 4'd1, 1'b0, 1'b0, 8'd0));
    // four fit in the queue, the fifth is dropped
    for (int i = 1; i <= 5; i++) begin
      send_item(KIND_REQUEST, make_tone(16'(i * 1000), 16'd30, 16'd0, 4'd0, 1'b0, 1'b0, 8'd0));
    end
    // background while busy is dropped
    send_item(KIND_REQUEST, make_tone(16'd440, 16'd50, 16'd0, 4'd0, 1'b0, 1'b1, 8'd0));
    repeat (4) send_tick();
  endtask

  task automatic test_preempt_and_background();
    apply_settings(5'd7, 3'd1, 3'd0, 3'sd2, 16'd150, 16'd15000, 8'd10);
    send_item(KIND_REQUEST, make_tone(16'h0000, 16'hffff, 16'd0, 4'd0, 1'b1, 1'b1, 8'd0));
    // foreground replaces a running background tone without waiting
    send_item(KIND_REQUEST, make_tone(16'd880, 16'd40, 16'd5, 4'd2, 1'b0, 1'b0, 8'd0));
    send_item(KIND_REQUEST, make_tone(16'd300, 16'd20, 16'd0, 4'd0, 1'b0, 1'b1, 8'd0));
    // zero length tone: next tick sees idle and pops the queue
    send_item(KIND_REQUEST, make_tone(16'd1200, 16'd0, 16'd0, 4'hf, 1'b1, 1'b0, 8'd0));
    send_tick();
  endtask

  task automatic test_sweep_and_scaling();
    // inverted clamp window with the largest tick
    apply_settings(5'd0, -3'sd2, -3'sd1, 3'sd1, 16'd1000, 16'd900, 8'd255);
    send_item(KIND_REQUEST, make_tone(16'd5000, 16'hffff, 16'd0, 4'd0, 1'b1, 1'b0, 8'd127));
    send_tick();
    // zero tick never expires the tone
    apply_settings(5'd0, -3'sd1, 3'sd1, 3'd0, 16'd0, 16'hffff, 8'd0);
    send_item(KIND_REQUEST, make_tone(16'd100, 16'd1000, 16'd0, 4'd0, 1'b1, 1'b0, 8'h80));
    send_tick();
    // downward sweep into the lower clamp, then on through the pause
    apply_settings(5'd0, 3'sd2, 3'sd2, -3'sd2, 16'd0, 16'hffff, 8'd1);
    send_item(KIND_REQUEST, make_tone(16'd200, 16'd1, 16'd5, 4'd0, 1'b1, 1'b0, 8'h80));
    repeat (4) send_tick();
  endtask

  task automatic test_backpressure();
    random_settings();
    @(posedge clk);
    hold_cycles = 60;
    quiet_tx = 1'b1;
    repeat (30) send_random();
    quiet_tx = 1'b0;
    // sender stops until every result is back
    wait_drained();
  endtask

  task automatic test_quiet_stretch();
    random_settings();
    @(posedge clk);
    quiet_tx = 1'b1;
    quiet_rx = 1'b1;
    repeat (120) send_random();
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 6; p++) begin
      random_settings();
      repeat (95) send_random();
    end
  endtask

  // receiver side
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= quiet_rx || ($urandom_range(99) >= 27);
      end
    end
  end

  always @(posedge clk) begin : check_result
    buzz_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_buzz.size() == 0) begin
        $error("result with no transaction waiting for it");
        errors++;
      end else begin
        want = expected_buzz.pop_front();
        checked++;
        if (sounding !== want.sounding) begin
          $error("sounding: expected %0d, actual %0d", want.sounding, sounding);
          errors++;
        end
        if (out_freq !== want.freq) begin
          $error("out_freq: expected %0d, actual %0d", want.freq, out_freq);
          errors++;
        end
        if (out_level !== want.level) begin
          $error("out_level: expected %0d, actual %0d", $signed(want.level), out_level);
          errors++;
        end
        if (busy_res !== want.busy) begin
          $error("busy_res: expected %0d, actual %0d", want.busy, busy_res);
          errors++;
        end
        if (queued !== want.queued) begin
          $error("queued: expected %0d, actual %0d", want.queued, queued);
          errors++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    kind         = KIND_REQUEST;
    tone_freq    = '0;
    tone_len     = '0;
    tone_pause   = '0;
    repeat_count = '0;
    urgent       = 1'b0;
    background   = 1'b0;
    sweep_step   = '0;
    set_pitch    = '0;
    set_scale    = '0;
    set_beep     = '0;
    set_vario    = '0;
    set_lo       = 16'd150;
    set_hi       = 16'd15000;
    set_tick     = 8'd10;
    tone_left    = '0;
    pause_left   = '0;
    cur_hz       = '0;
    rep_hz       = '0;
    rep_len      = '0;
    rep_pause    = '0;
    reps_left    = '0;
    rep_bg       = 1'b0;
    rep_step     = '0;
    buzzer_on    = 1'b0;
    level_now    = '0;
    fifo_rd      = 0;
    fifo_wr      = 0;
    fifo_fill    = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_queue_and_drop();
    test_preempt_and_background();
    test_sweep_and_scaling();
    test_backpressure();
    test_quiet_stretch();
    test_random_traffic();

    wait_drained();
    $display("%0d transactions sent, %0d results checked, %0d register settings",
             sent, checked, phases);
    $display("exercised queueing, drops, preemption, clamped sweeps, length scaling, stalls");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* buzzer_tone_sequencer.f */
rtl/bts_pkg.sv
rtl/bts_queue.sv
rtl/buzzer_tone_sequencer.sv
rtl/bts_checker.sv
dv/tb_top.sv
